// File: design/angular_limit_impulse_solver_unit_assert.svh
// Assertion macros for the angular limit impulse solver.
// Included by the modules that check their own logic; needs no other file.
`ifndef ANGULAR_LIMIT_IMPULSE_SOLVER_UNIT_ASSERT_SVH
`define ANGULAR_LIMIT_IMPULSE_SOLVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define ALISU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("alisu assertion failed");

// Next-cycle implication, checked outside reset.
`define ALISU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("alisu assertion failed");

`else

`define ALISU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ALISU_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/alisu_pkg.sv
// Package for the angular limit impulse solver: payload structs, codes,
// sequencer states and the 32-bit saturation helper. Depends on nothing.
`default_nettype none

package alisu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    typedef enum logic {
        OP_PREPARE = 1'b0,
        OP_ITERATE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_LIMIT     = 3'd0,
        CFG_UPPER_LIMIT     = 3'd1,
        CFG_REST_OFFSET     = 3'd2,
        CFG_SLOP_TOLERANCE  = 3'd3,
        CFG_CORRECTION_RATE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_op                operation;
        logic signed [31:0] angle_a;
        logic signed [31:0] angle_b;
        logic        [30:0] inv_inertia_a;
        logic        [30:0] inv_inertia_b;
        logic signed [31:0] ang_vel_a;
        logic signed [31:0] ang_vel_b;
        logic        [30:0] inv_step;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_vel_a;
        logic signed [31:0] new_vel_b;
        logic               limit_engaged;
        logic               lower_side;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_PMUL_C,
        S_PMUL_S,
        S_PBIAS,
        S_DIV,
        S_PFIN,
        S_ITER,
        S_IMUL_M,
        S_IUPD,
        S_IMUL_A,
        S_IMUL_B,
        S_IFIN
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] res;
        if (x > 64'(MAX32)) begin
            res = MAX32;
        end else if (x < 64'(MIN32)) begin
            res = MIN32;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/angular_limit_impulse_solver_unit.sv
// A prepare that finds a breached limit forms the effective mass in a restoring
// divider, one quotient bit per cycle; an active iterate forms three products on the
// one shared 32x32 multiplier. Numbers are Q16.16 by default. One item is in work at
// a time: a result waits in its final state until the output register is free, and
// the next beat is taken the cycle after the result is registered. Reset (synchronous,
// active low) clears the joint state and loads default registers.
`default_nettype none

`include "angular_limit_impulse_solver_unit_assert.svh"

module angular_limit_impulse_solver_unit #(
    parameter int FRAC_BITS = alisu_pkg::FRAC_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [alisu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [alisu_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  alisu_pkg::t_in                        i_in,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output alisu_pkg::t_out                       o_out
);
    import alisu_pkg::*;

    // With more than 19 fraction bits the reset rate of 0.2 needs more than the
    // 17 bits of a write.
    localparam int RATE_W = (FRAC_BITS > 19) ? FRAC_BITS - 2 : 17;
    localparam logic [RATE_W-1:0] RATE_RST = RATE_W'((64'd1 << FRAC_BITS) / 5);
    localparam int DIV_STEPS = 2 * FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_STEPS + 1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DIV_STEPS);

    // Configuration registers.
    logic signed [31:0] r_lower;
    logic signed [31:0] r_upper;
    logic signed [31:0] r_rest;
    logic        [30:0] r_slop;
    logic [RATE_W-1:0]  r_rate;

    // Joint state.
    logic               r_active;
    logic               r_below;
    logic signed [31:0] r_bias;
    logic signed [31:0] r_mass;
    logic signed [31:0] r_accum;

    // Sequencer and datapath.
    t_state             r_state;
    t_state             n_state;
    t_in                r_in;
    logic signed [31:0] r_t;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_wa_new;
    logic        [31:0] r_sum;
    logic               r_zero;
    logic        [31:0] r_rem;
    logic        [31:0] r_q;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_o_valid;
    t_out               r_out;

    logic               out_free;
    logic               accept;
    logic               finish;

    // Shared multiplier operands and the scaled product.
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod_sh;
    logic signed [31:0] fprod;

    // Prepare compare.
    logic signed [33:0] phi;
    logic signed [34:0] e_lo;
    logic signed [34:0] e_hi;
    logic signed [34:0] c_sel;
    logic               hit_lo;
    logic               hit_hi;

    // Iterate update.
    logic signed [31:0] vel_sum;
    logic signed [31:0] lam;
    logic signed [32:0] acc_raw;
    logic signed [32:0] acc_clamp;
    logic signed [31:0] acc_new;
    logic signed [31:0] delta;

    // Divider step.
    logic        [32:0] rem_sh;
    logic               rem_ge;
    logic        [32:0] rem_sub;
    logic signed [31:0] mass_q;

    assign out_free    = !r_o_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_o_valid;
    assign o_out       = r_out;

    assign prod_sh = r_prod >>> FRAC_BITS;
    assign fprod   = sat32(prod_sh);

    assign phi    = 34'(r_in.angle_b) - 34'(r_in.angle_a) - 34'(r_rest);
    assign hit_lo = phi < 34'(r_lower);
    assign hit_hi = phi > 34'(r_upper);
    assign e_lo   = 35'(phi) - 35'(r_lower) + 35'($signed({1'b0, r_slop}));
    assign e_hi   = 35'(phi) - 35'(r_upper) - 35'($signed({1'b0, r_slop}));
    always_comb begin
        if (hit_lo) begin
            c_sel = (e_lo < 0) ? e_lo : 35'sd0;
        end else begin
            c_sel = (e_hi > 0) ? e_hi : 35'sd0;
        end
    end

    assign vel_sum = sat32(64'(34'(r_in.ang_vel_b) - 34'(r_in.ang_vel_a) + 34'(r_bias)));
    assign lam     = sat32(-prod_sh);
    assign acc_raw = 33'(r_accum) + 33'(lam);
    always_comb begin
        if (r_below) begin
            acc_clamp = (acc_raw < 0) ? 33'sd0 : acc_raw;
        end else begin
            acc_clamp = (acc_raw > 0) ? 33'sd0 : acc_raw;
        end
    end
    assign acc_new = sat32(64'(acc_clamp));
    assign delta   = sat32(64'(33'(acc_new) - 33'(r_accum)));

    // The dividend is one set bit at position 2*FRAC_BITS; it enters on the first step.
    assign rem_sh  = {r_rem, (r_cnt == CNT_TOP)};
    assign rem_ge  = rem_sh >= {1'b0, r_sum};
    assign rem_sub = rem_sh - {1'b0, r_sum};
    assign mass_q  = (r_zero || r_ovf || r_q[31]) ? MAX32 : $signed(r_q);

    // The last iterate product is held while the result waits for the output register.
    always_comb begin
        case (r_state)
            S_PMUL_C: begin
                mul_a = r_t;
                mul_b = $signed(32'(r_rate));
            end
            S_PMUL_S: begin
                mul_a = fprod;
                mul_b = $signed({1'b0, r_in.inv_step});
            end
            S_IMUL_M: begin
                mul_a = r_mass;
                mul_b = r_t;
            end
            S_IMUL_A: begin
                mul_a = $signed({1'b0, r_in.inv_inertia_a});
                mul_b = r_t;
            end
            S_IMUL_B, S_IFIN: begin
                mul_a = $signed({1'b0, r_in.inv_inertia_b});
                mul_b = r_t;
            end
            default: begin
                mul_a = 32'sd0;
                mul_b = 32'sd0;
            end
        endcase
    end

    // Next state and handshake.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        finish     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = (i_in.operation == OP_ITERATE) ? S_ITER : S_PREP;
                end
            end
            S_PREP: begin
                if (hit_lo || hit_hi) begin
                    n_state = S_PMUL_C;
                end else if (out_free) begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PMUL_C: n_state = S_PMUL_S;
            S_PMUL_S: n_state = S_PBIAS;
            S_PBIAS:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_PFIN;
                end
            end
            S_PFIN: begin
                if (out_free) begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ITER: begin
                if (r_active) begin
                    n_state = S_IMUL_M;
                end else if (out_free) begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_IMUL_M: n_state = S_IUPD;
            S_IUPD:   n_state = S_IMUL_A;
            S_IMUL_A: n_state = S_IMUL_B;
            S_IMUL_B: n_state = S_IFIN;
            S_IFIN: begin
                if (out_free) begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The user must write configuration only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= '0;
            r_rest  <= '0;
            r_slop  <= '0;
            r_rate  <= RATE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOWER_LIMIT:     r_lower <= $signed(i_cfg_data);
                CFG_UPPER_LIMIT:     r_upper <= $signed(i_cfg_data);
                CFG_REST_OFFSET:     r_rest  <= $signed(i_cfg_data);
                CFG_SLOP_TOLERANCE:  r_slop  <= i_cfg_data[30:0];
                CFG_CORRECTION_RATE: r_rate  <= RATE_W'(i_cfg_data[16:0]);
                default: ;
            endcase
        end
    end

    // Joint state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_below   <= 1'b0;
            r_bias    <= '0;
            r_mass    <= '0;
            r_accum   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= finish || (r_o_valid && !i_out_ready);
            case (r_state)
                S_PREP: begin
                    if (hit_lo || hit_hi) begin
                        r_below <= hit_lo;
                    end else if (finish) begin
                        r_active <= 1'b0;
                    end
                end
                S_PBIAS: r_bias <= fprod;
                S_PFIN: begin
                    if (finish) begin
                        r_mass   <= mass_q;
                        r_accum  <= '0;
                        r_active <= 1'b1;
                    end
                end
                S_IUPD: r_accum <= acc_new;
                default: ;
            endcase
        end
    end

    // Datapath registers; no reset needed.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        if (accept) begin
            r_in <= i_in;
        end
        case (r_state)
            S_PREP: begin
                r_t    <= sat32(64'(c_sel));
                r_sum  <= 32'(r_in.inv_inertia_a) + 32'(r_in.inv_inertia_b);
                r_zero <= (r_in.inv_inertia_a == '0) && (r_in.inv_inertia_b == '0);
            end
            S_PBIAS: begin
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= 1'b0;
                r_cnt <= CNT_TOP;
            end
            S_DIV: begin
                r_rem <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
                r_q   <= {r_q[30:0], rem_ge};
                r_ovf <= r_ovf | r_q[31];
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_ITER:   r_t      <= vel_sum;
            S_IUPD:   r_t      <= delta;
            S_IMUL_B: r_wa_new <= sat32(64'(33'(r_in.ang_vel_a) - 33'(fprod)));
            default: ;
        endcase
        if (finish) begin
            r_out.limit_engaged <= (r_state == S_PFIN) || (r_state == S_IFIN);
            r_out.lower_side    <= ((r_state == S_PFIN) || (r_state == S_IFIN)) && r_below;
            if (r_state == S_IFIN) begin
                r_out.new_vel_a <= r_wa_new;
                r_out.new_vel_b <= sat32(64'(33'(r_in.ang_vel_b) + 33'(fprod)));
            end else begin
                r_out.new_vel_a <= r_in.ang_vel_a;
                r_out.new_vel_b <= r_in.ang_vel_b;
            end
        end
    end

    `ALISU_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, accept, !o_in_ready)
    `ALISU_ASSERT_IMP(a_side_needs_limit, i_clk, i_rst_n,
        o_out_valid && !o_out.limit_engaged, !o_out.lower_side)
    `ALISU_ASSERT_IMP(a_div_count_range, i_clk, i_rst_n, r_state == S_DIV, r_cnt <= CNT_TOP)
    `ALISU_ASSERT_IMP(a_lower_impulse_sign, i_clk, i_rst_n,
        (r_state == S_IDLE) && r_active && r_below, !r_accum[31])
    `ALISU_ASSERT_IMP(a_upper_impulse_sign, i_clk, i_rst_n,
        (r_state == S_IDLE) && r_active && !r_below, r_accum[31] || (r_accum == '0))

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the angular limit impulse solver unit.
// Holds its own fixed-point joint predictor and paces both valid/ready channels.
// Depends on alisu_pkg and angular_limit_impulse_solver_unit.
module tb_top;
    import alisu_pkg::*;

    localparam int     FB          = FRAC_BITS_DEF;
    localparam longint LMAX        = 64'sd2147483647;
    localparam longint LMIN        = -64'sd2147483648;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     SETTLE      = 2 * FB + 8;
    localparam int     NUM_PHASES  = 7;
    localparam int     PHASE_BEATS = 210;

    logic     i_clk     = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_we    = 1'b0;
    t_cfg_idx cfg_index = CFG_LOWER_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic     in_valid  = 1'b0;
    t_in      in_beat   = '0;
    logic     out_ready = 1'b0;
    logic     in_ready;
    logic     out_valid;
    t_out     out_beat;

    angular_limit_impulse_solver_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Predictor copy of the registers and the joint state.
    longint lim_lo = 0, lim_hi = 0, rest_ofs = 0, slop = 0, rate = (1 << FB) / 5;
    logic   jt_active = 1'b0, jt_below = 1'b0;
    longint jt_bias = 0, jt_mass = 0, jt_accum = 0;

    t_in  beat_pending_q[$];
    t_out vel_expect_q[$];

    int send_idle_pct = 0, stall_pct = 0;
    int send_burst = 0, stall_burst = 0;
    logic in_took = 1'b0;
    int cycle_cnt = 0, mismatch_cnt = 0, checked_cnt = 0;
    int n_beats = 0, n_prep = 0, n_engaged = 0, n_iter_live = 0, n_settings = 0;

    function automatic longint sx32(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint clip32(input longint x);
        if (x > LMAX) return LMAX;
        if (x < LMIN) return LMIN;
        return x;
    endfunction

    // Floor-rounded fixed-point product, saturated to 32 bits.
    function automatic longint mul_fix(input longint x, input longint y);
        return clip32((x * y) >>> FB);
    endfunction

    function automatic t_out predict_joint_velocity(input t_in b);
        t_out   res;
        longint phi, err, c, inert_sum, quot, s, lam, acc, d;
        longint wa, wb, iia, iib;
        logic   hit;
        wa  = sx32(b.ang_vel_a);
        wb  = sx32(b.ang_vel_b);
        iia = longint'(b.inv_inertia_a);
        iib = longint'(b.inv_inertia_b);
        if (b.operation == OP_PREPARE) begin
            n_prep++;
            phi = sx32(b.angle_b) - sx32(b.angle_a) - rest_ofs;
            c   = 0;
            hit = 1'b1;
            // The lower limit is tested first, so crossed limits resolve to the lower side.
            if (phi < lim_lo) begin
                err = phi - lim_lo + slop;
                c = (err < 0) ? err : 0;
                jt_below = 1'b1;
            end else if (phi > lim_hi) begin
                err = phi - lim_hi - slop;
                c = (err > 0) ? err : 0;
                jt_below = 1'b0;
            end else begin
                hit = 1'b0;
            end
            if (hit) begin
                n_engaged++;
                c = clip32(c);
                jt_bias = mul_fix(mul_fix(c, rate), longint'(b.inv_step));
                inert_sum = iia + iib;
                if (inert_sum == 0) begin
                    jt_mass = LMAX;
                end else begin
                    quot = (longint'(1) << (2 * FB)) / inert_sum;
                    jt_mass = (quot > LMAX) ? LMAX : quot;
                end
                jt_accum = 0;
            end
            jt_active = hit;
        end else if (jt_active) begin
            n_iter_live++;
            s   = clip32(wb - wa + jt_bias);
            lam = clip32(-((jt_mass * s) >>> FB));
            acc = jt_accum + lam;
            if (jt_below) begin
                if (acc < 0) acc = 0;
            end else begin
                if (acc > 0) acc = 0;
            end
            acc = clip32(acc);
            d = clip32(acc - jt_accum);
            jt_accum = acc;
            wa = clip32(wa - mul_fix(iia, d));
            wb = clip32(wb + mul_fix(iib, d));
        end
        res.new_vel_a     = wa[31:0];
        res.new_vel_b     = wb[31:0];
        res.limit_engaged = jt_active;
        res.lower_side    = jt_active & jt_below;
        return res;
    endfunction

    // Stimulus value pickers: extremes, full random words and values near zero.
    function automatic logic [31:0] near_zero(input int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return near_zero('h30000);
        endcase
    endfunction

    function automatic logic [30:0] pick_gain();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: return 31'h0;
            1: return 31'h7FFF_FFFF;
            2, 3: return w[30:0];
            4: return 31'h3C_0000;
            default: return 31'($urandom_range(1, 'h40000));
        endcase
    endfunction

    function automatic t_in random_beat();
        t_in b;
        b.operation     = t_op'($urandom_range(0, 1));
        b.angle_a       = pick_word();
        b.angle_b       = pick_word();
        b.inv_inertia_a = pick_gain();
        b.inv_inertia_b = pick_gain();
        b.ang_vel_a     = pick_word();
        b.ang_vel_b     = pick_word();
        b.inv_step      = pick_gain();
        return b;
    endfunction

    task automatic push_beat(input t_op op, input logic [31:0] aa, input logic [31:0] ab,
                             input logic [30:0] ga, input logic [30:0] gb,
                             input logic [31:0] va, input logic [31:0] vb,
                             input logic [30:0] stp);
        t_in b;
        b.operation     = op;
        b.angle_a       = aa;
        b.angle_b       = ab;
        b.inv_inertia_a = ga;
        b.inv_inertia_b = gb;
        b.ang_vel_a     = va;
        b.ang_vel_b     = vb;
        b.inv_step      = stp;
        beat_pending_q.push_back(b);
    endtask

    // Mostly a prepare aimed near a limit followed by a run of iterates on the same
    // bodies, with fully random beats mixed in as noise.
    task automatic queue_scenarios(input int count);
        int     emitted;
        longint phi, dlt;
        logic [30:0] ga, gb;
        t_in    b;
        emitted = 0;
        while (emitted < count) begin
            if ($urandom_range(0, 99) < 80) begin
                ga  = pick_gain();
                gb  = pick_gain();
                dlt = longint'($urandom_range(0, 'h20000));
                if ($urandom_range(0, 2) == 0) dlt += slop;
                case ($urandom_range(0, 3))
                    0: phi = lim_lo - dlt;
                    1: phi = lim_hi + dlt;
                    2: phi = lim_lo + (lim_hi - lim_lo) / 2;
                    default: phi = lim_lo + dlt;
                endcase
                b = random_beat();
                b.operation     = OP_PREPARE;
                b.inv_inertia_a = ga;
                b.inv_inertia_b = gb;
                b.angle_a       = near_zero('h80000);
                b.angle_b       = 32'(sx32(b.angle_a) + rest_ofs + phi);
                beat_pending_q.push_back(b);
                emitted++;
                repeat ($urandom_range(1, 8)) begin
                    b = random_beat();
                    b.operation     = OP_ITERATE;
                    b.inv_inertia_a = ga;
                    b.inv_inertia_b = gb;
                    if ($urandom_range(0, 3) != 0) begin
                        b.ang_vel_a = near_zero('h40000);
                        b.ang_vel_b = near_zero('h40000);
                    end
                    beat_pending_q.push_back(b);
                    emitted++;
                end
            end else begin
                beat_pending_q.push_back(random_beat());
                emitted++;
            end
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (beat_pending_q.size() != 0 || in_valid || vel_expect_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last register.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_LOWER_LIMIT:     lim_lo   = sx32(val);
            CFG_UPPER_LIMIT:     lim_hi   = sx32(val);
            CFG_REST_OFFSET:     rest_ofs = sx32(val);
            CFG_SLOP_TOLERANCE:  slop     = longint'(val[30:0]);
            CFG_CORRECTION_RATE: rate     = longint'(val[16:0]);
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int ph);
        logic [31:0] lo, hi, ofs, slp, rt;
        case (ph)
            1: begin
                lo = -32'sh8000; hi = 32'sh8000; ofs = 32'h1000; slp = 32'h100; rt = 13107;
            end
            2: begin
                lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; ofs = 32'h8000_0000;
                slp = 32'h7FFF_FFFF; rt = 32'h1_0000;
            end
            3: begin
                lo = 32'sh1_0000; hi = -32'sh1_0000; ofs = 32'h0; slp = 32'h0; rt = 32'h0;
            end
            5: begin
                lo = 32'h7FFF_FFFF; hi = 32'h8000_0000; ofs = 32'h7FFF_FFFF;
                slp = 32'h0; rt = 32'h1;
            end
            default: begin
                lo  = near_zero('h40000);
                hi  = lo + $urandom_range(0, 'h80000);
                ofs = ($urandom_range(0, 1) != 0) ? $urandom : near_zero('h10000);
                slp = ($urandom_range(0, 1) != 0) ? ($urandom & 32'h7FFF_FFFF)
                                                  : $urandom_range(0, 'h4000);
                rt  = $urandom_range(0, 'h1_0000);
            end
        endcase
        write_reg(CFG_LOWER_LIMIT, lo);
        write_reg(CFG_UPPER_LIMIT, hi);
        write_reg(CFG_REST_OFFSET, ofs);
        write_reg(CFG_SLOP_TOLERANCE, slp);
        write_reg(CFG_CORRECTION_RATE, rt);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Input driver: a presented beat holds until it is taken.
    always @(negedge i_clk) begin
        if (send_burst > 0) begin
            send_burst--;
        end else if ($urandom_range(0, 99) < 3) begin
            send_burst = $urandom_range(5, 40);
        end
        if (!in_valid || in_took) begin
            if (beat_pending_q.size() != 0 &&
                !(send_burst == 0 && $urandom_range(0, 99) < send_idle_pct)) begin
                in_beat  <= beat_pending_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_burst > 0) begin
            stall_burst--;
        end else if ($urandom_range(0, 99) < 3) begin
            stall_burst = $urandom_range(5, 40);
        end
        out_ready <= !(stall_burst == 0 && $urandom_range(0, 99) < stall_pct);
    end

    // Monitor: predicts on each accepted input beat and checks each result beat.
    always @(posedge i_clk) begin
        t_out want;
        in_took <= in_valid && in_ready;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                n_beats++;
                vel_expect_q.push_back(predict_joint_velocity(in_beat));
            end
            if (out_valid && out_ready) begin
                if (vel_expect_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("ERROR: result beat with nothing expected: va=%h vb=%h e=%b l=%b",
                                 out_beat.new_vel_a, out_beat.new_vel_b,
                                 out_beat.limit_engaged, out_beat.lower_side);
                    mismatch_cnt++;
                end else begin
                    want = vel_expect_q.pop_front();
                    checked_cnt++;
                    if (out_beat.new_vel_a !== want.new_vel_a ||
                        out_beat.new_vel_b !== want.new_vel_b ||
                        out_beat.limit_engaged !== want.limit_engaged ||
                        out_beat.lower_side !== want.lower_side) begin
                        if (mismatch_cnt < 10)
                            $display("ERROR: result %0d: expected va=%h vb=%h e=%b l=%b, got va=%h vb=%h e=%b l=%b",
                                     checked_cnt, want.new_vel_a, want.new_vel_b,
                                     want.limit_engaged, want.lower_side,
                                     out_beat.new_vel_a, out_beat.new_vel_b,
                                     out_beat.limit_engaged, out_beat.lower_side);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("ERROR: timed out after %0d cycles, %0d results outstanding",
                     cycle_cnt, vel_expect_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed beats under the reset register values (both limits at zero).
        push_beat(OP_ITERATE, 32'h0, 32'h0, 31'h1_0000, 31'h1_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 31'h3C_0000);
        push_beat(OP_PREPARE, 32'h1_2345, 32'h1_2345, 31'h1_0000, 31'h1_0000,
                  32'h0, 32'h0, 31'h3C_0000);
        // Relative angle far below the limit with zero inertia: error and mass saturate.
        push_beat(OP_PREPARE, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0, 31'h0,
                  32'h0, 32'h0, 31'h7FFF_FFFF);
        push_beat(OP_ITERATE, 32'h0, 32'h0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 31'h0);
        push_beat(OP_ITERATE, 32'h0, 32'h0, 31'h100, 31'h200, 32'h0, 32'h0, 31'h0);
        // Far above the upper limit; an inertia sum of one overflows the reciprocal.
        push_beat(OP_PREPARE, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0, 31'h1,
                  32'h1234, 32'h5678, 31'h3C_0000);
        push_beat(OP_ITERATE, 32'h0, 32'h0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 31'h0);
        push_beat(OP_ITERATE, 32'h0, 32'h0, 31'h0, 31'h1, 32'h0, 32'h7FFF_FFFF, 31'h0);
        push_beat(OP_PREPARE, 32'h0, 32'h1, 31'h1_0000, 31'h1_0000,
                  32'h0, 32'h0, 31'h3C_0000);
        push_beat(OP_ITERATE, 32'h0, 32'h0, 31'h1_0000, 31'h1_0000,
                  32'h1_0000, 32'hFFFF_0000, 31'h0);
        push_beat(OP_ITERATE, 32'h0, 32'h0, 31'h1_0000, 31'h1_0000,
                  32'hFFFF_0000, 32'h1_0000, 31'h0);
        push_beat(OP_ITERATE, 32'h0, 32'h0, 31'h1_0000, 31'h1_0000,
                  32'h2_0000, 32'h0, 31'h0);
        // A prepare inside the limits clears only the engaged flag.
        push_beat(OP_PREPARE, 32'h5555, 32'h5555, 31'h0, 31'h0, 32'h0, 32'h0, 31'h0);
        push_beat(OP_ITERATE, 32'h0, 32'h0, 31'h1_0000, 31'h1_0000,
                  32'hDEAD_BEEF, 32'h1357_9BDF, 31'h0);
        push_beat(OP_PREPARE, 32'h1, 32'h0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h0, 32'h0, 31'h3C_0000);
        push_beat(OP_ITERATE, 32'h0, 32'h0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h0, 32'h8000_0000, 31'h0);
        push_beat(OP_ITERATE, 32'h0, 32'h0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h0, 31'h0);
        push_beat(OP_PREPARE, 32'h4_0000, 32'h0, 31'h2_0000, 31'h8000,
                  32'h0, 32'h0, 31'h0);
        push_beat(OP_ITERATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) apply_setting(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            queue_scenarios(PHASE_BEATS / 2);
            // The sender holds off mid-phase until every result is back.
            wait_drained();
            queue_scenarios(PHASE_BEATS - PHASE_BEATS / 2);
            wait_drained();
        end

        $display("Covered %0d input beats: %0d prepares (%0d engaged a limit), %0d iterates on an engaged limit",
                 n_beats, n_prep, n_engaged, n_iter_live);
        $display("Checked %0d result beats over %0d register settings and four pacing modes",
                 checked_cnt, n_settings + 1);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
